/* sv/sem_pkg.sv */
// Package for the RGB Sobel edge magnitude block: request types, register
// indexes and sizing constants. No dependencies.
package sem_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int FW_BITS        = 11;
  localparam int FH_BITS        = 13;
  localparam int CFG_DATA_BITS  = 13;
  localparam int FW_RESET       = 640;
  localparam int FH_RESET       = 480;
  localparam int ENERGY_BITS    = 21;
  localparam int QUEUE_DEPTH    = 8;
  // Squares at or above this value always round to 255 or more
  localparam int SAT_ENERGY     = 65281;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] edge_red;
    logic [7:0] edge_green;
    logic [7:0] edge_blue;
    logic       frame_done;
  } out_item_t;

  // Gradient energy Gx^2+Gy^2 per channel, red first
  typedef struct packed {
    logic [2:0][ENERGY_BITS-1:0] energy;
    logic                        frame_done;
  } energy_item_t;

endpackage

/* sv/sem_front.sv */
// Front end: accepts pixels, keeps the two line stores and the 3x3 window,
// and forms per-channel gradient energy. Depends on sem_pkg.
module sem_front #(
  parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  sem_pkg::in_item_t                 in_item,
  input  logic                              cfg_we,
  input  sem_pkg::cfg_index_t               cfg_index,
  input  logic [sem_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output logic                              q_push,
  output sem_pkg::energy_item_t             q_item
);
  import sem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // Configuration
  logic [FW_BITS-1:0] fw_r;
  logic [FH_BITS-1:0] fh_r;
  logic [WW-1:0]      w_lim;
  logic [HW-1:0]      h_lim;
  logic [CW-1:0]      wm1;
  logic [RW-1:0]      hm1;

  always_comb begin
    if (fw_r == '0) begin
      w_lim = WW'(1);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      w_lim = WW'(MAX_WIDTH);
    end else begin
      w_lim = WW'(fw_r);
    end
    if (fh_r == '0) begin
      h_lim = HW'(1);
    end else if (32'(fh_r) > MAX_HEIGHT) begin
      h_lim = HW'(MAX_HEIGHT);
    end else begin
      h_lim = HW'(fh_r);
    end
    wm1 = CW'(w_lim - WW'(1));
    hm1 = RW'(h_lim - HW'(1));
  end

  // Position counters; the input row only needs to saturate at two
  logic [CW-1:0] icol_r, icol_nxt, ocol_r, ocol_nxt;
  logic [1:0]    irow_r, irow_nxt;
  logic [RW-1:0] orow_r, orow_nxt;
  logic          emit, top, bot, left, right, done;
  logic [8:0]    mask;

  always_comb begin
    emit  = (irow_r == 2'd2) || (irow_r == 2'd1 && icol_r != '0);
    top   = (orow_r == '0);
    bot   = (orow_r == hm1);
    left  = (ocol_r == '0);
    right = (ocol_r == wm1);
    done  = bot && right;
    for (int k = 0; k < 9; k++) begin
      mask[k] = (k / 3 == 0 && top) || (k / 3 == 2 && bot) ||
                (k % 3 == 0 && left) || (k % 3 == 2 && right);
    end
    icol_nxt = icol_r;
    irow_nxt = irow_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (accept) begin
      if (icol_r == wm1) begin
        icol_nxt = '0;
        if (irow_r != 2'd2) irow_nxt = irow_r + 2'd1;
      end else begin
        icol_nxt = icol_r + CW'(1);
      end
      if (emit) begin
        if (done) begin
          icol_nxt = '0;
          irow_nxt = '0;
          ocol_nxt = '0;
          orow_nxt = '0;
        end else if (right) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + RW'(1);
        end else begin
          ocol_nxt = ocol_r + CW'(1);
        end
      end
    end
    if (cfg_we) begin
      icol_nxt = '0;
      irow_nxt = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
    end
  end

  // Stage B / C control
  logic          b_valid_r, b_emit_r, fwd_r, c_valid_r;
  logic [CW-1:0] b_col_r;
  logic [8:0]    b_mask_r, c_mask_r;
  logic          b_done_r, c_done_r;
  logic [23:0]   b_pix_r, older_q_r, newer_q_r, fwd_old_r, fwd_new_r;
  logic [23:0]   colin0, colin1;
  logic [23:0]   win_r [3][3];
  logic [23:0]   pix;

  assign pix = in_item.operation ? 24'd0 :
               {in_item.pixel_red, in_item.pixel_green, in_item.pixel_blue};
  // Forwarded values cover a read of the column written in the same cycle
  assign colin0 = fwd_r ? fwd_old_r : older_q_r;
  assign colin1 = fwd_r ? fwd_new_r : newer_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r      <= FW_BITS'(FW_RESET);
      fh_r      <= FH_BITS'(FH_RESET);
      icol_r    <= '0;
      irow_r    <= '0;
      ocol_r    <= '0;
      orow_r    <= '0;
      b_valid_r <= 1'b0;
      b_emit_r  <= 1'b0;
      fwd_r     <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  fw_r <= cfg_data[FW_BITS-1:0];
          CFG_FRAME_HEIGHT: fh_r <= cfg_data[FH_BITS-1:0];
          default: ;
        endcase
      end
      icol_r    <= icol_nxt;
      irow_r    <= irow_nxt;
      ocol_r    <= ocol_nxt;
      orow_r    <= orow_nxt;
      b_valid_r <= accept;
      if (accept) begin
        b_emit_r <= emit;
        fwd_r    <= b_valid_r && (b_col_r == icol_r);
      end
      c_valid_r <= b_valid_r && b_emit_r;
    end
  end

  // Line stores: read at accept, written in the following cycle
  logic [23:0] older_mem [MAX_WIDTH];
  logic [23:0] newer_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (accept) begin
      older_q_r <= older_mem[icol_r];
      newer_q_r <= newer_mem[icol_r];
    end
    if (b_valid_r) begin
      older_mem[b_col_r] <= colin1;
      newer_mem[b_col_r] <= b_pix_r;
    end
  end

  // Payload registers and window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (b_valid_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= colin0;
      win_r[1][2] <= colin1;
      win_r[2][2] <= b_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_col_r   <= icol_r;
      b_pix_r   <= pix;
      b_mask_r  <= mask;
      b_done_r  <= done;
      fwd_old_r <= colin1;
      fwd_new_r <= b_pix_r;
    end
    if (b_valid_r) begin
      c_mask_r <= b_mask_r;
      c_done_r <= b_done_r;
    end
  end

  // Sobel sums and energy for one channel (cells indexed row*3+col)
  function automatic logic [ENERGY_BITS-1:0] grad_energy(input logic [8:0][7:0] p);
    logic [11:0] e [9];
    logic [11:0] gx, gy, ax, ay;
    for (int k = 0; k < 9; k++) e[k] = {4'b0, p[k]};
    gx = (e[2] + (e[5] << 1) + e[8]) - (e[0] + (e[3] << 1) + e[6]);
    gy = (e[6] + (e[7] << 1) + e[8]) - (e[0] + (e[1] << 1) + e[2]);
    ax = gx[11] ? 12'(-gx) : gx;
    ay = gy[11] ? 12'(-gy) : gy;
    return ENERGY_BITS'(ax[9:0] * ax[9:0]) + ENERGY_BITS'(ay[9:0] * ay[9:0]);
  endfunction

  logic [8:0][7:0] cells [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        cells[ch][k] = c_mask_r[k] ? 8'd0 : win_r[k / 3][k % 3][16 - 8 * ch +: 8];
      end
      q_item.energy[2 - ch] = grad_energy(cells[ch]);
    end
    q_item.frame_done = c_done_r;
  end

  assign q_push = c_valid_r;

endmodule

/* sv/sem_queue.sv */
// Short queue of gradient energy requests between front and back end.
// Depends on sem_pkg.
module sem_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sem_pkg::energy_item_t wr_item,
  input  logic                  pop,
  output sem_pkg::energy_item_t rd_item,
  output logic                  not_empty,
  output logic                  low_room
);
  import sem_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  energy_item_t   mem_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PW:0]    count_r;

  assign not_empty = (count_r != '0);
  // Two requests may still be in flight in the front end
  assign low_room  = (count_r > (PW + 1)'(QUEUE_DEPTH - 3));
  assign rd_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      unique case ({push, pop})
        2'b10:   count_r <= count_r + (PW + 1)'(1);
        2'b01:   count_r <= count_r - (PW + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_item;
  end

endmodule

/* sv/sem_back.sv */
// Back end: rounded integer square root of each channel's energy, one bit
// per cycle, clamped to 255, held in an output register. Depends on sem_pkg.
module sem_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_not_empty,
  input  sem_pkg::energy_item_t q_item,
  output logic                  q_pop,
  input  logic                  pop,
  output logic                  empty,
  output sem_pkg::out_item_t    out_item
);
  import sem_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CALC  = 4'b0010,
    ST_ROUND = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  bit_r;
  logic [15:0] s_r    [3];
  logic        sat_r  [3];
  logic [7:0]  root_r [3];
  logic [7:0]  trial  [3];
  logic [7:0]  edge_v [3];
  logic [16:0] lim    [3];
  logic        done_r;

  assign q_pop = (state_r == ST_IDLE) && q_not_empty;
  assign empty = (state_r != ST_HOLD);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (q_not_empty) state_nxt = ST_CALC;
      ST_CALC:  if (bit_r == 3'd0) state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_HOLD;
      ST_HOLD:  if (pop) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Trial bit and rounding per channel
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      trial[ch] = root_r[ch] | (8'd1 << bit_r);
      lim[ch]   = 17'(root_r[ch] * root_r[ch]) + 17'(root_r[ch]) + 17'd1;
      if (sat_r[ch] || (17'(s_r[ch]) >= lim[ch] && root_r[ch] == 8'd255)) begin
        edge_v[ch] = 8'd255;
      end else if (17'(s_r[ch]) >= lim[ch]) begin
        edge_v[ch] = root_r[ch] + 8'd1;
      end else begin
        edge_v[ch] = root_r[ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    priority case (1'b1)
      q_pop: begin
        bit_r  <= 3'd7;
        done_r <= q_item.frame_done;
        for (int ch = 0; ch < 3; ch++) begin
          sat_r[ch]  <= q_item.energy[2 - ch] >= ENERGY_BITS'(SAT_ENERGY);
          s_r[ch]    <= q_item.energy[2 - ch][15:0];
          root_r[ch] <= '0;
        end
      end
      state_r == ST_CALC: begin
        bit_r <= bit_r - 3'd1;
        for (int ch = 0; ch < 3; ch++) begin
          if (16'(trial[ch] * trial[ch]) <= s_r[ch] && 17'(trial[ch] * trial[ch]) < 17'h10000)
            root_r[ch] <= trial[ch];
        end
      end
      state_r == ST_ROUND: begin
        out_item.edge_red   <= edge_v[0];
        out_item.edge_green <= edge_v[1];
        out_item.edge_blue  <= edge_v[2];
        out_item.frame_done <= done_r;
      end
      default: ;
    endcase
  end

endmodule

/* sv/sobel_edge_magnitude_rgb.sv */
// Top level of the RGB Sobel edge magnitude block: front end, request queue
// and root back end. Depends on sem_pkg, sem_front, sem_queue, sem_back.
//
// Usage: pixels enter in raster order through push/full with in_item;
// operation 1 is a flush tick carrying a zero pixel. A result leaves
// through empty/pop with out_item once its pixel is frame_width+1 items
// behind the newest one; after a frame's last pixel, frame_width+1 flush
// ticks drain the window and the last result carries frame_done.
// Registers frame_width (index 0) and frame_height (index 1) are written
// through cfg_we/cfg_index/cfg_data while idle; a write restarts the frame.
// Input items that produce no result are taken one per cycle while full is low.
// The back end handles one request at a time (load, 8 root steps one bit each,
// rounding, hand-off) and pops the next only after the receiver has taken the
// held result; the bit-serial root unit sets the sustained rate. Accepted
// requests pass the front end's stage B and C registers before the queue write.
// A stalled receiver leaves its result on out_item; the queue fills and full
// rises once six requests wait, which leaves room for the two still in the
// front end. Reset restores 640x480, clears the window and counters; line
// stores are not cleared and need no pass.
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  sem_pkg::in_item_t                 in_item,
  output logic                              empty,
  input  logic                              pop,
  output sem_pkg::out_item_t                out_item,
  input  logic                              cfg_we,
  input  sem_pkg::cfg_index_t               cfg_index,
  input  logic [sem_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import sem_pkg::*;

  logic         accept, q_push, q_pop, q_not_empty, q_low_room;
  energy_item_t q_wr, q_rd;

  assign full   = q_low_room;
  assign accept = push && !q_low_room;

  sem_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_item    (q_wr)
  );

  sem_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_item   (q_wr),
    .pop       (q_pop),
    .rd_item   (q_rd),
    .not_empty (q_not_empty),
    .low_room  (q_low_room)
  );

  sem_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (q_rd),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_item    (out_item)
  );

endmodule

/* tb/sem_checker.sv */
// Checker for the RGB Sobel edge magnitude block: watches the request, result
// and register ports, predicts each result and compares. Depends on sem_pkg.
`timescale 1ns / 100ps

module sem_checker
  import sem_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic                     full,
  input  in_item_t                 in_item,
  input  logic                     empty,
  input  logic                     pop,
  input  out_item_t                out_item,
  input  logic                     cfg_we,
  input  cfg_index_t               cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       fail_cnt,
  output int                       pending
);

  localparam int MAXW = MAX_WIDTH_DEF;
  localparam int MAXH = MAX_HEIGHT_DEF;

  logic [23:0]        older_line [MAXW];
  logic [23:0]        newer_line [MAXW];
  logic [23:0]        win [3][3];
  logic [FW_BITS-1:0] width_reg;
  logic [FH_BITS-1:0] height_reg;
  int unsigned        in_col, in_row, out_col, out_row;
  out_item_t          expected_edges [$];

  assign pending = expected_edges.size();

  // Rounded integer square root, clamped to 8 bits
  function automatic logic [7:0] rounded_root(int unsigned s);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = 4096;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= s) lo = mid;
      else hi = mid;
    end
    if (s >= lo * lo + lo + 1) lo++;
    return (lo > 255) ? 8'd255 : lo[7:0];
  endfunction

  function automatic int unsigned clip(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // One accepted request: shift the line stores and window, maybe emit
  task automatic take_pixel(in_item_t it);
    int unsigned w, h, col, sh;
    logic [23:0] pix, c0, c1;
    bit          emit;
    int          gx, gy, v;
    out_item_t   res;
    w = clip(width_reg, MAXW);
    h = clip(height_reg, MAXH);
    pix = it.operation ? 24'd0 : {it.pixel_red, it.pixel_green, it.pixel_blue};
    col = (in_col >= MAXW) ? 0 : in_col;
    c0 = older_line[col];
    c1 = newer_line[col];
    older_line[col] = c1;
    newer_line[col] = pix;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = c0;
    win[1][2] = c1;
    win[2][2] = pix;
    emit = (longint'(in_row) * w + in_col) >= longint'(w) + 1;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return;
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      sh = 16 - 8 * ch;
      for (int r = 0; r < 3; r++) begin
        if (r == 0 && out_row == 0) continue;
        if (r == 2 && out_row + 1 >= h) continue;
        for (int c = 0; c < 3; c++) begin
          if (c == 0 && out_col == 0) continue;
          if (c == 2 && out_col + 1 >= w) continue;
          v = (win[r][c] >> sh) & 8'hFF;
          gx += v * (c - 1) * ((r == 1) ? 2 : 1);
          gy += v * (r - 1) * ((c == 1) ? 2 : 1);
        end
      end
      case (ch)
        0: res.edge_red   = rounded_root(gx * gx + gy * gy);
        1: res.edge_green = rounded_root(gx * gx + gy * gy);
        default: res.edge_blue = rounded_root(gx * gx + gy * gy);
      endcase
    end
    if (out_row + 1 >= h && out_col + 1 >= w) begin
      res.frame_done = 1'b1;
      {in_col, in_row, out_col, out_row} = '0;
    end else begin
      res.frame_done = 1'b0;
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    expected_edges.push_back(res);
  endtask

  // Compare one accepted result with the oldest expectation
  task automatic check_edges(out_item_t got);
    out_item_t exp_item;
    if (expected_edges.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      fail_cnt++;
      return;
    end
    exp_item = expected_edges.pop_front();
    if (got.edge_red !== exp_item.edge_red) begin
      $display("%0t: edge_red exp %0d got %0d", $time, exp_item.edge_red, got.edge_red);
      fail_cnt++;
    end
    if (got.edge_green !== exp_item.edge_green) begin
      $display("%0t: edge_green exp %0d got %0d", $time, exp_item.edge_green,
               got.edge_green);
      fail_cnt++;
    end
    if (got.edge_blue !== exp_item.edge_blue) begin
      $display("%0t: edge_blue exp %0d got %0d", $time, exp_item.edge_blue, got.edge_blue);
      fail_cnt++;
    end
    if (got.frame_done !== exp_item.frame_done) begin
      $display("%0t: frame_done exp %0b got %0b", $time, exp_item.frame_done,
               got.frame_done);
      fail_cnt++;
    end
  endtask

  // Everything is sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst_n) begin
      fail_cnt   = 0;
      width_reg  = FW_RESET;
      height_reg = FH_RESET;
      {in_col, in_row, out_col, out_row} = '0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win[r][c] = '0;
      expected_edges.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FRAME_WIDTH) width_reg = cfg_data[FW_BITS-1:0];
        else height_reg = cfg_data[FH_BITS-1:0];
        {in_col, in_row, out_col, out_row} = '0;
      end
      if (pop && !empty) check_edges(out_item);
      if (push && !full) take_pixel(in_item);
    end
  end

  // Leftover expectations at the end are reported by the top through pending
  final if (expected_edges.size() != 0)
    $display("%0t: %0d results never arrived", $time, expected_edges.size());

endmodule

/* tb/tb_top.sv */
// Top of the testbench for sobel_edge_magnitude_rgb: clock, reset, request
// and register stimulus, receiver stalls and verdict. Depends on sem_pkg, sem_checker.
`timescale 1ns / 100ps

module tb_top;
  import sem_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_WAIT  = 40;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     push = 1'b0;
  logic                     full;
  in_item_t                 in_item = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  out_item_t                out_item;
  logic                     cfg_we = 1'b0;
  cfg_index_t               cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  int                       fail_cnt, pending;
  int                       item_cnt = 0;
  int                       cycle_cnt = 0;

  always #5 clk = ~clk;

  sobel_edge_magnitude_rgb u_dut (
    .clk, .rst_n, .push, .full, .in_item, .empty, .pop, .out_item,
    .cfg_we, .cfg_index, .cfg_data
  );

  sem_checker u_checker (
    .clk, .rst_n, .push, .full, .in_item, .empty, .pop, .out_item,
    .cfg_we, .cfg_index, .cfg_data, .fail_cnt, .pending
  );

  // Mostly back to back, some short gaps, a few long ones
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] chan_val();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_req(logic flush, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= '{operation: flush, pixel_red: r, pixel_green: g, pixel_blue: b};
    do @(posedge clk); while (full);
    item_cnt++;
  endtask

  task automatic send_rand(logic flush);
    send_req(flush, chan_val(), chan_val(), chan_val());
  endtask

  // Register write once all results are out and the block has settled
  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] val);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A full frame plus its drain; noise sprinkles flushes and drain pixels
  task automatic send_frame(int w, int h, bit noisy);
    for (int i = 0; i < w * h; i++) send_rand(noisy && $urandom_range(0, 19) == 0);
    for (int i = 0; i <= w; i++) send_rand(!(noisy && $urandom_range(0, 5) == 0));
  endtask

  // Receiver: random pops, one long hold so the queue backs up into full
  initial begin
    int taken;
    int gap;
    taken = 0;
    @(posedge rst_n);
    forever begin
      gap = idle_len();
      if (taken == 150) gap = 400;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      taken++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    int w, h, rand_start, settle;
    w = 1;
    h = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Widest row clipped to the maximum; a short partial row, then restart
    write_reg(CFG_FRAME_WIDTH, 13'h7FF);
    write_reg(CFG_FRAME_HEIGHT, 13'd2);
    repeat (20) send_rand(1'b0);

    // Zero registers act as a 1x1 frame
    write_reg(CFG_FRAME_WIDTH, 13'd0);
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    send_req(1'b0, 8'd255, 8'd0, 8'd128);
    send_rand(1'b1);
    send_rand(1'b1);

    // 3x3 of extremes: saturation, flush before the last pixel, pixel in drain
    write_reg(CFG_FRAME_WIDTH, 13'd3);
    write_reg(CFG_FRAME_HEIGHT, 13'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 7) send_rand(1'b1);
      else if (i[0]) send_req(1'b0, 8'd255, 8'd255, 8'd255);
      else send_req(1'b0, 8'd0, 8'd0, 8'd0);
    end
    send_req(1'b1, 8'd255, 8'd255, 8'd255);
    send_req(1'b0, 8'd255, 8'd170, 8'd85);
    send_rand(1'b1);
    send_rand(1'b1);

    // Tallest setting clipped; partial frame then restarted by a write
    write_reg(CFG_FRAME_WIDTH, 13'd1);
    write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
    repeat (4) send_rand(1'b0);

    // Random frames, mostly small, some wider, some cut short
    rand_start = item_cnt;
    while (item_cnt - rand_start < 600) begin
      if (item_cnt == rand_start || $urandom_range(0, 2) == 0) begin
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        h = $urandom_range(1, 6);
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_BITS'(w));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_BITS'(h));
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 12)) send_rand(1'($urandom_range(0, 1)));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_BITS'(h));
      end else begin
        send_frame(w, h, 1'($urandom_range(0, 1)));
      end
    end

    // Drain
    push <= 1'b0;
    while (pending != 0) @(posedge clk);
    settle = 0;
    while (settle < DRAIN_WAIT) begin
      @(posedge clk);
      settle++;
    end
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
